// ----- rtl/btsq_pkg.sv -----
// ----------------------------------------------------------------------------
// btsq_pkg
// shared types, constants and note pattern tables of the buzzer tone sequencer
// ----------------------------------------------------------------------------
package btsq_pkg;

   localparam int MAX_NOTES    = 8;
   localparam int NUM_PATTERNS = 13;
   localparam int NOTE_IDX_W   = $clog2(MAX_NOTES);
   localparam int LEN_W        = $clog2(MAX_NOTES + 1);

   // request kinds
   typedef enum logic [2:0] {
      REQ_TICK   = 3'd0,
      REQ_PLAY   = 3'd1,
      REQ_LOCK   = 3'd2,
      REQ_UNLOCK = 3'd3,
      REQ_RSSI   = 3'd4,
      REQ_ALARM  = 3'd5
   } req_kind_type;

   // pattern ids
   localparam logic [3:0] PAT_LAST_MODE     = 4'd4;
   localparam logic [3:0] PAT_LAST_CATEGORY = 4'd9;
   localparam logic [3:0] PAT_CONNECT       = 4'd10;
   localparam logic [3:0] PAT_DISCONNECT    = 4'd11;
   localparam logic [3:0] PAT_WARNING       = 4'd12;

   // timing limits in ms, siren pitches in Hz
   localparam logic [8:0]  NOTE_ELAPSED_MAX  = 9'd511;
   localparam logic [9:0]  CLICK_PERIOD_MAX  = 10'd1000;
   localparam logic [4:0]  CLICK_ELAPSED_MAX = 5'd31;
   localparam logic [4:0]  CLICK_LEN         = 5'd25;
   localparam logic [10:0] ALARM_LEN         = 11'd1500;
   localparam logic [8:0]  SIREN_PERIOD_LAST = 9'd299;
   localparam logic [8:0]  SIREN_HALF        = 9'd150;
   localparam logic [11:0] SIREN_HIGH_HZ     = 12'd2500;
   localparam logic [11:0] SIREN_LOW_HZ      = 12'd1800;

   // geiger clicker math
   localparam logic signed [7:0] RSSI_FLOOR   = -8'sd95;
   localparam logic signed [7:0] RSSI_CEIL    = -8'sd30;
   localparam logic signed [7:0] RSSI_RESET   = -8'sd90;
   localparam logic [11:0]       CLICK_BASE_HZ = 12'd500;
   localparam logic [9:0]        CLICK_BASE_MS = 10'd1000;
   // x/13 == (x * 40330) >> 19 for x below 2^18; folded with the 400 and 184 factors
   localparam int                RECIP_SHIFT  = 19;
   localparam logic [23:0]       FREQ_RECIP   = 24'(400 * 40330);
   localparam logic [22:0]       IVAL_RECIP   = 23'(184 * 40330);

   typedef struct packed {
      logic        alarm_busy;
      logic        jingle_busy;
      logic [11:0] tone_freq;
      logic        tone_on;
   } rsp_type;

   localparam logic [11:0] ROM_FREQ [NUM_PATTERNS][MAX_NOTES] = '{
      '{0: 523,  1: 659,  2: 784,  default: 0},
      '{0: 880,  1: 1175, 2: 1760, default: 0},
      '{0: 600,  1: 900,  2: 1200, default: 0},
      '{0: 1000, 1: 1400, 2: 1800, 3: 2400, default: 0},
      '{0: 1200, 1: 900,  2: 600,  default: 0},
      '{0: 1200, 1: 0,    2: 1200, default: 0},
      '{0: 900,  1: 0,    2: 900,  3: 0, 4: 900, default: 0},
      '{0: 1000, 1: 1400, 2: 1800, 3: 2300, default: 0},
      '{0: 2000, 1: 0, 2: 2000, 3: 0, 4: 2000, 5: 0, 6: 2000, default: 0},
      '{0: 800,  1: 600,  default: 0},
      '{0: 1500, 1: 2500, default: 0},
      '{0: 2500, 1: 1500, default: 0},
      '{0: 800,  1: 600,  default: 0}
   };

   localparam logic [8:0] ROM_DUR [NUM_PATTERNS][MAX_NOTES] = '{
      '{0: 80,  1: 80,  2: 120, default: 0},
      '{0: 60,  1: 60,  2: 120, default: 0},
      '{0: 70,  1: 70,  2: 120, default: 0},
      '{0: 50,  1: 50,  2: 50,  3: 100, default: 0},
      '{0: 70,  1: 70,  2: 140, default: 0},
      '{0: 250, 1: 130, 2: 250, default: 0},
      '{0: 260, 1: 80,  2: 90,  3: 70, 4: 90, default: 0},
      '{0: 60,  1: 60,  2: 60,  3: 110, default: 0},
      '{0: 45, 1: 55, 2: 45, 3: 55, 4: 45, 5: 55, 6: 45, default: 0},
      '{0: 150, 1: 200, default: 0},
      '{0: 100, 1: 150, default: 0},
      '{0: 150, 1: 100, default: 0},
      '{0: 150, 1: 200, default: 0}
   };

   localparam logic [LEN_W-1:0] ROM_LEN [NUM_PATTERNS] = '{
      LEN_W'(3), LEN_W'(3), LEN_W'(3), LEN_W'(4), LEN_W'(3), LEN_W'(3), LEN_W'(5),
      LEN_W'(4), LEN_W'(7), LEN_W'(2), LEN_W'(2), LEN_W'(2), LEN_W'(2)
   };

   function automatic logic [LEN_W-1:0] pat_len(input logic [3:0] pat);
      logic [LEN_W-1:0] n;
      n = '0;
      if (pat < 4'(NUM_PATTERNS)) begin
         n = ROM_LEN[pat];
      end
      return n;
   endfunction

   function automatic logic [11:0] note_freq(input logic [3:0] pat,
                                              input logic [NOTE_IDX_W-1:0] idx);
      logic [11:0] f;
      f = '0;
      if (pat < 4'(NUM_PATTERNS)) begin
         f = ROM_FREQ[pat][idx];
      end
      return f;
   endfunction

   function automatic logic [8:0] note_dur(input logic [3:0] pat,
                                            input logic [NOTE_IDX_W-1:0] idx);
      logic [8:0] d;
      d = '0;
      if (pat < 4'(NUM_PATTERNS)) begin
         d = ROM_DUR[pat][idx];
      end
      return d;
   endfunction

endpackage

// ----- rtl/btsq_geiger.sv -----
// ----------------------------------------------------------------------------
// btsq_geiger
// click pitch and click interval from the locked target's rssi
// ----------------------------------------------------------------------------
module btsq_geiger (
   input  logic signed [7:0] rssi,
   output logic [11:0]       click_freq,
   output logic [9:0]        click_interval
);

   logic signed [7:0] clamped;
   logic [6:0]        above_floor;
   logic [30:0]       freq_prod;
   logic [29:0]       ival_prod;

   always_comb begin
      clamped = rssi;
      if (rssi < btsq_pkg::RSSI_FLOOR) begin
         clamped = btsq_pkg::RSSI_FLOOR;
      end else if (rssi > btsq_pkg::RSSI_CEIL) begin
         clamped = btsq_pkg::RSSI_CEIL;
      end
   end

   // distance above the floor, 0..65
   assign above_floor = 7'(clamped - btsq_pkg::RSSI_FLOOR);

   // constant multiplies stand in for the divide by 65
   assign freq_prod = 31'(above_floor) * 31'(btsq_pkg::FREQ_RECIP);
   assign ival_prod = 30'(above_floor) * 30'(btsq_pkg::IVAL_RECIP);

   assign click_freq     = btsq_pkg::CLICK_BASE_HZ
                         + 12'(freq_prod[btsq_pkg::RECIP_SHIFT +: 11]);
   assign click_interval = btsq_pkg::CLICK_BASE_MS
                         - ival_prod[btsq_pkg::RECIP_SHIFT +: 10];

endmodule

// ----- rtl/btsq_step.sv -----
// ----------------------------------------------------------------------------
// btsq_step
// sequencer state and its update for each request
// ----------------------------------------------------------------------------
module btsq_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [2:0]        step_kind,
   input  logic [3:0]        step_pattern,
   input  logic signed [7:0] step_rssi,
   input  logic              csr_we,
   input  logic              csr_wdata,
   output btsq_pkg::rsp_type result
);

   localparam int IW = btsq_pkg::NOTE_IDX_W;

   logic        enable_ff, enable_in;
   logic [3:0]  pattern_ff, pattern_in;
   logic [IW-1:0] note_idx_ff, note_idx_in;
   logic [8:0]  note_elapsed_ff, note_elapsed_in;
   logic        jingle_ff, jingle_in;
   logic        note_started_ff, note_started_in;
   logic        locked_ff, locked_in;
   logic signed [7:0] rssi_ff, rssi_in;
   logic [9:0]  since_click_ff, since_click_in;
   logic [4:0]  click_elapsed_ff, click_elapsed_in;
   logic        click_ff, click_in;
   logic [10:0] alarm_elapsed_ff, alarm_elapsed_in;
   logic        alarm_ff, alarm_in;
   logic [8:0]  phase_ff, phase_in;
   logic        tone_on_ff, tone_on_in;
   logic [11:0] tone_freq_ff, tone_freq_in;

   logic [11:0] click_freq;
   logic [9:0]  click_interval;

   btsq_geiger u_geiger (
      .rssi           (rssi_ff),
      .click_freq     (click_freq),
      .click_interval (click_interval)
   );

   always_comb begin
      logic [btsq_pkg::LEN_W-1:0] len;
      logic [11:0]                f;
      enable_in        = enable_ff;
      pattern_in       = pattern_ff;
      note_idx_in      = note_idx_ff;
      note_elapsed_in  = note_elapsed_ff;
      jingle_in        = jingle_ff;
      note_started_in  = note_started_ff;
      locked_in        = locked_ff;
      rssi_in          = rssi_ff;
      since_click_in   = since_click_ff;
      click_elapsed_in = click_elapsed_ff;
      click_in         = click_ff;
      alarm_elapsed_in = alarm_elapsed_ff;
      alarm_in         = alarm_ff;
      phase_in         = phase_ff;
      tone_on_in       = tone_on_ff;
      tone_freq_in     = tone_freq_ff;
      len              = btsq_pkg::pat_len(pattern_ff);
      f                = '0;

      if (csr_we) begin
         enable_in = csr_wdata;
         if (!csr_wdata) begin
            tone_on_in   = 1'b0;
            tone_freq_in = '0;
         end
      end

      if (step_en) begin
         case (step_kind)
            btsq_pkg::REQ_TICK: begin
               // counters first; the siren phase wraps, the others saturate
               phase_in = (phase_ff == btsq_pkg::SIREN_PERIOD_LAST) ? '0 : phase_ff + 9'd1;
               if (note_elapsed_ff < btsq_pkg::NOTE_ELAPSED_MAX)
                  note_elapsed_in = note_elapsed_ff + 9'd1;
               if (since_click_ff < btsq_pkg::CLICK_PERIOD_MAX)
                  since_click_in = since_click_ff + 10'd1;
               if (click_elapsed_ff < btsq_pkg::CLICK_ELAPSED_MAX)
                  click_elapsed_in = click_elapsed_ff + 5'd1;
               if (alarm_elapsed_ff < btsq_pkg::ALARM_LEN)
                  alarm_elapsed_in = alarm_elapsed_ff + 11'd1;

               // pattern player
               if (jingle_ff) begin
                  if (btsq_pkg::LEN_W'(note_idx_ff) >= len) begin
                     jingle_in    = 1'b0;
                     note_idx_in  = '0;
                     tone_on_in   = 1'b0;
                     tone_freq_in = '0;
                  end else if (!note_started_ff) begin
                     note_started_in = 1'b1;
                     note_elapsed_in = '0;
                     f = btsq_pkg::note_freq(pattern_ff, note_idx_ff);
                     tone_on_in   = (f != '0) && enable_ff;
                     tone_freq_in = ((f != '0) && enable_ff) ? f : '0;
                  end else if (note_elapsed_in >= btsq_pkg::note_dur(pattern_ff, note_idx_ff))
                  begin
                     tone_on_in   = 1'b0;
                     tone_freq_in = '0;
                     note_idx_in  = note_idx_ff + IW'(1);
                     if (note_idx_in != '0 && btsq_pkg::LEN_W'(note_idx_in) < len) begin
                        note_elapsed_in = '0;
                        f = btsq_pkg::note_freq(pattern_ff, note_idx_in);
                        if (f != '0 && enable_ff) begin
                           tone_on_in   = 1'b1;
                           tone_freq_in = f;
                        end
                     end else begin
                        jingle_in       = 1'b0;
                        note_idx_in     = '0;
                        note_started_in = 1'b0;
                     end
                  end
               end

               // geiger clicker runs only with no pattern playing
               if (!jingle_in) begin
                  if (click_ff && click_elapsed_in >= btsq_pkg::CLICK_LEN) begin
                     tone_on_in   = 1'b0;
                     tone_freq_in = '0;
                     click_in     = 1'b0;
                  end
                  if (locked_ff) begin
                     if (since_click_in >= click_interval) begin
                        click_in         = 1'b1;
                        click_elapsed_in = '0;
                        since_click_in   = '0;
                        if (enable_ff) begin
                           tone_on_in   = 1'b1;
                           tone_freq_in = click_freq;
                        end
                     end
                  end else if (!click_in && !alarm_ff) begin
                     tone_on_in   = 1'b0;
                     tone_freq_in = '0;
                  end
               end

               // siren overrides
               if (alarm_ff) begin
                  if (alarm_elapsed_in < btsq_pkg::ALARM_LEN) begin
                     if (enable_ff) begin
                        tone_on_in   = 1'b1;
                        tone_freq_in = (phase_in < btsq_pkg::SIREN_HALF) ?
                                       btsq_pkg::SIREN_HIGH_HZ : btsq_pkg::SIREN_LOW_HZ;
                     end
                  end else begin
                     alarm_in     = 1'b0;
                     tone_on_in   = 1'b0;
                     tone_freq_in = '0;
                  end
               end
            end
            btsq_pkg::REQ_PLAY: begin
               if (step_pattern <= btsq_pkg::PAT_LAST_MODE
                   || step_pattern == btsq_pkg::PAT_CONNECT
                   || step_pattern == btsq_pkg::PAT_DISCONNECT
                   || (step_pattern <= btsq_pkg::PAT_LAST_CATEGORY && !jingle_ff && !alarm_ff)
                   || (step_pattern == btsq_pkg::PAT_WARNING && !alarm_ff)) begin
                  pattern_in      = step_pattern;
                  note_idx_in     = '0;
                  note_started_in = 1'b0;
                  note_elapsed_in = '0;
                  jingle_in       = 1'b1;
               end
            end
            btsq_pkg::REQ_LOCK, btsq_pkg::REQ_RSSI: begin
               locked_in = 1'b1;
               rssi_in   = step_rssi;
            end
            btsq_pkg::REQ_UNLOCK: begin
               locked_in    = 1'b0;
               tone_on_in   = 1'b0;
               tone_freq_in = '0;
            end
            btsq_pkg::REQ_ALARM: begin
               if (!alarm_ff) begin
                  alarm_in         = 1'b1;
                  alarm_elapsed_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b1;
         pattern_ff       <= '0;
         note_idx_ff      <= '0;
         note_elapsed_ff  <= '0;
         jingle_ff        <= 1'b0;
         note_started_ff  <= 1'b0;
         locked_ff        <= 1'b0;
         rssi_ff          <= btsq_pkg::RSSI_RESET;
         since_click_ff   <= btsq_pkg::CLICK_PERIOD_MAX;
         click_elapsed_ff <= '0;
         click_ff         <= 1'b0;
         alarm_elapsed_ff <= '0;
         alarm_ff         <= 1'b0;
         phase_ff         <= '0;
         tone_on_ff       <= 1'b0;
         tone_freq_ff     <= '0;
      end else begin
         enable_ff        <= enable_in;
         pattern_ff       <= pattern_in;
         note_idx_ff      <= note_idx_in;
         note_elapsed_ff  <= note_elapsed_in;
         jingle_ff        <= jingle_in;
         note_started_ff  <= note_started_in;
         locked_ff        <= locked_in;
         rssi_ff          <= rssi_in;
         since_click_ff   <= since_click_in;
         click_elapsed_ff <= click_elapsed_in;
         click_ff         <= click_in;
         alarm_elapsed_ff <= alarm_elapsed_in;
         alarm_ff         <= alarm_in;
         phase_ff         <= phase_in;
         tone_on_ff       <= tone_on_in;
         tone_freq_ff     <= tone_freq_in;
      end
   end

   // result shows the state after this request
   assign result.tone_on     = tone_on_in;
   assign result.tone_freq   = tone_freq_in;
   assign result.jingle_busy = jingle_in;
   assign result.alarm_busy  = alarm_in;

   a_silent_freq_zero: assert property (@(posedge clock) disable iff (reset)
      !tone_on_ff |-> tone_freq_ff == '0)
      else $error("tone frequency held while silent");

   a_idle_index_zero: assert property (@(posedge clock) disable iff (reset)
      !jingle_ff |-> note_idx_ff == '0)
      else $error("note index left over after pattern end");

   a_alarm_bounded: assert property (@(posedge clock) disable iff (reset)
      alarm_ff |-> alarm_elapsed_ff <= btsq_pkg::ALARM_LEN)
      else $error("alarm timer past siren length");

   a_muted_silent: assert property (@(posedge clock) disable iff (reset)
      (!enable_ff && !$past(step_en)) |-> !tone_on_ff)
      else $error("tone sounding while muted");

endmodule

// ----- rtl/btsq_out_queue.sv -----
// ----------------------------------------------------------------------------
// btsq_out_queue
// two-entry result queue between the step logic and the result channel
// ----------------------------------------------------------------------------
module btsq_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  btsq_pkg::rsp_type push_data,
   output logic              can_push,
   output logic              pop_valid,
   input  logic              pop,
   output btsq_pkg::rsp_type pop_data
);

   btsq_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign can_push  = count_ff != 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && can_push;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |=> count_ff != 2'd3)
      else $error("result queue overflow");

   a_ptrs_match_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

// ----- rtl/buzzer_tone_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// buzzer_tone_sequencer_core
// buzzer tone sequencer: note pattern player, geiger clicker and siren
// ----------------------------------------------------------------------------
// a result is written into the registered result queue when its request is taken and offered from it in order
// throughput: one request per cycle while the result queue has room, set by the state update
// a two-entry result queue keeps requests flowing while a result waits
// reset: synchronous, active high; buzzer enabled, all timers and tone cleared,
// target rssi -90 dBm and click interval counter saturated at 1000 ms
module buzzer_tone_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // pattern_id [3:0], rssi_dbm [11:4], zero [15:12]
   input  logic [2:0]  req_tuser,   // req_type [2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // tone_on [0], tone_freq [12:1], jingle_busy [13],
                                    // alarm_busy [14], zero [15]
   // buzzer enable register
   input  logic        csr_we,
   input  logic        csr_wdata
);

   logic              req_transfer;
   btsq_pkg::rsp_type step_result;
   btsq_pkg::rsp_type rsp_data;

   // a request is taken whenever the result queue has room
   assign req_transfer = req_tvalid && req_tready;

   btsq_step u_step (
      .clock        (clock),
      .reset        (reset),
      .step_en      (req_transfer),
      .step_kind    (req_tuser),
      .step_pattern (req_tdata[3:0]),
      .step_rssi    (req_tdata[11:4]),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .result       (step_result)
   );

   // result register plus skid entry
   btsq_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_transfer),
      .push_data (step_result),
      .can_push  (req_tready),
      .pop_valid (rsp_tvalid),
      .pop       (rsp_tready),
      .pop_data  (rsp_data)
   );

   // pack result fields, lowest first
   assign rsp_tdata = {1'b0, rsp_data};

endmodule
